// ===== design/pafc_pkg.sv =====
`timescale 1ns / 1ps

package pafc_pkg;

  localparam int BLOCK_BYTES_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  localparam logic [7:0] CRC_POLY = 8'h85;
  localparam logic [7:0] CMD_READ_BYTE = 8'h02;
  localparam logic [7:0] CMD_WRITE_BYTE = 8'h03;

  // input command codes
  localparam logic [1:0] CMD_READ_REQ = 2'd0;
  localparam logic [1:0] CMD_WRITE_REQ = 2'd1;
  localparam logic [1:0] CMD_PAYLOAD = 2'd2;
  localparam logic [1:0] CMD_RESPONSE = 2'd3;

  // access mode
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_READING = 2'd1;
  localparam logic [1:0] MODE_WRITING = 2'd2;

  // result kinds and status codes
  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_LENGTH = 2'd1;
  localparam logic [1:0] ST_CRC = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    logic [1:0] status;
  } res_t;

  // one queued item: up to three results, cnt tells how many
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      res;
  } job_t;

  function automatic logic [4:0] addr_sum_entry(input logic [3:0] idx);
    logic [4:0] v;
    case (idx)
      4'd0:    v = 5'h01;
      4'd1:    v = 5'h1A;
      4'd2:    v = 5'h0D;
      4'd3:    v = 5'h1C;
      4'd4:    v = 5'h0E;
      4'd5:    v = 5'h07;
      4'd6:    v = 5'h19;
      4'd7:    v = 5'h16;
      4'd8:    v = 5'h0B;
      4'd9:    v = 5'h1F;
      4'd10:   v = 5'h15;
      default: v = 5'h00;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] address_word(input logic [10:0] addr);
    logic [4:0] sum;
    sum = 5'h00;
    // address bit 10 selects the first entry
    for (int k = 0; k < 11; k++) begin
      if (addr[k]) begin
        sum = sum ^ addr_sum_entry(4'(10 - k));
      end
    end
    return {addr, sum};
  endfunction

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/pafc_in_if.sv =====
`timescale 1ns / 1ps

interface pafc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [10:0] block_address;
  logic [7:0]  data_byte;
  logic        frame_end;

  modport source (output valid, command, block_address, data_byte, frame_end, input ready);
  modport sink (input valid, command, block_address, data_byte, frame_end, output ready);
endinterface

// ===== design/pafc_out_if.sv =====
`timescale 1ns / 1ps

interface pafc_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] tx_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, result_kind, tx_byte, status, last, input ready);
  modport sink (input valid, result_kind, tx_byte, status, last, output ready);
endinterface

// ===== design/pafc_front.sv =====
`timescale 1ns / 1ps

module pafc_front #(
  parameter int BLOCK_BYTES = pafc_pkg::BLOCK_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  pafc_in_if.sink          in_ch,
  output pafc_pkg::job_t   push_job,
  output logic             push_valid,
  input  logic             push_ready
);

  localparam logic [pafc_pkg::CNT_W-1:0] BlockCnt = pafc_pkg::CNT_W'(BLOCK_BYTES);

  logic [1:0]                  mode_r, mode_nxt;
  logic [pafc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]                  crc_r, crc_nxt, crc_upd, crc_rd;
  logic [15:0]                 word;
  logic                        accept;
  logic                        job_vld;
  pafc_pkg::job_t              job;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign crc_upd     = pafc_pkg::crc8_byte(crc_r, in_ch.data_byte);
  assign cnt_inc     = (cnt_r == pafc_pkg::CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign word        = pafc_pkg::address_word(in_ch.block_address);

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    job      = '0;
    job_vld  = 1'b0;
    crc_rd   = crc_r;
    case (in_ch.command)
      pafc_pkg::CMD_READ_REQ, pafc_pkg::CMD_WRITE_REQ: begin
        job_vld         = 1'b1;
        job.cnt         = 2'd3;
        job.res[0].kind = pafc_pkg::KIND_TX;
        job.res[0].tx   = (in_ch.command == pafc_pkg::CMD_READ_REQ) ?
                          pafc_pkg::CMD_READ_BYTE : pafc_pkg::CMD_WRITE_BYTE;
        job.res[1].kind = pafc_pkg::KIND_TX;
        job.res[1].tx   = word[15:8];
        job.res[2].kind = pafc_pkg::KIND_TX;
        job.res[2].tx   = word[7:0];
        // a new request drops any access in flight
        mode_nxt = (in_ch.command == pafc_pkg::CMD_READ_REQ) ?
                   pafc_pkg::MODE_READING : pafc_pkg::MODE_WRITING;
        cnt_nxt  = '0;
        crc_nxt  = '0;
      end
      pafc_pkg::CMD_PAYLOAD: begin
        if (mode_r == pafc_pkg::MODE_WRITING) begin
          job_vld         = 1'b1;
          job.res[0].kind = pafc_pkg::KIND_TX;
          job.res[0].tx   = in_ch.data_byte;
          if (cnt_inc >= BlockCnt) begin
            // block complete: append the data CRC
            job.cnt         = 2'd2;
            job.res[1].kind = pafc_pkg::KIND_TX;
            job.res[1].tx   = crc_upd;
            mode_nxt        = pafc_pkg::MODE_IDLE;
            cnt_nxt         = '0;
            crc_nxt         = '0;
          end else begin
            job.cnt = 2'd1;
            cnt_nxt = cnt_inc;
            crc_nxt = crc_upd;
          end
        end
      end
      pafc_pkg::CMD_RESPONSE: begin
        if (mode_r == pafc_pkg::MODE_READING) begin
          // the CRC byte itself folds in by XOR, so a match leaves zero
          if (cnt_r < BlockCnt) begin
            crc_rd = crc_upd;
          end else if (cnt_r == BlockCnt) begin
            crc_rd = crc_r ^ in_ch.data_byte;
          end
          if (in_ch.frame_end) begin
            job_vld         = 1'b1;
            job.cnt         = 2'd1;
            job.res[0].kind = pafc_pkg::KIND_STATUS;
            if (cnt_r != BlockCnt) begin
              job.res[0].status = pafc_pkg::ST_LENGTH;
            end else if (crc_rd != 8'h00) begin
              job.res[0].status = pafc_pkg::ST_CRC;
            end else begin
              job.res[0].status = pafc_pkg::ST_OK;
            end
            mode_nxt = pafc_pkg::MODE_IDLE;
            cnt_nxt  = '0;
            crc_nxt  = '0;
          end else begin
            cnt_nxt = cnt_inc;
            crc_nxt = crc_rd;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign push_job   = job;
  assign push_valid = accept && job_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pafc_pkg::MODE_IDLE;
      cnt_r  <= '0;
      crc_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      crc_r  <= crc_nxt;
    end
  end

endmodule

// ===== design/pafc_queue.sv =====
`timescale 1ns / 1ps

module pafc_queue #(
  parameter int DEPTH = pafc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pafc_pkg::job_t push_job,
  input  logic           push_valid,
  output logic           push_ready,
  output pafc_pkg::job_t head_job,
  output logic           head_valid,
  input  logic           pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  pafc_pkg::job_t   slots_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != FullCnt);
  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/pafc_back.sv =====
`timescale 1ns / 1ps

module pafc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  pafc_pkg::job_t head_job,
  input  logic           head_valid,
  output logic           pop,
  pafc_out_if.source     out_ch
);

  logic [1:0]     idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           load, is_last;
  pafc_pkg::res_t cur;
  pafc_pkg::res_t res_r;
  logic           last_r;

  assign cur     = head_job.res[idx_r];
  assign is_last = (idx_r == head_job.cnt - 2'd1);
  // refill the output register when it is empty or being taken
  assign load    = head_valid && (!out_valid_r || out_ch.ready);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= cur;
      last_r <= is_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = res_r.kind;
  assign out_ch.tx_byte     = res_r.tx;
  assign out_ch.status      = res_r.status;
  assign out_ch.last        = last_r;

endmodule

// ===== design/pak_access_framer_checker_unit.sv =====
`timescale 1ns / 1ps

// Memory-pak access framer and reply checker. Takes one item per clock on
// in_ch whenever the result queue has room: a read or write request turns
// into the command byte and the two address/checksum bytes, write payload
// bytes are echoed with the CRC-8 (poly 0x85) appended after the last block
// byte, and read response bytes are checked, ending in one status result.
// Items that produce no result still need queue room. Results leave
// through a registered output at one per clock while out_ch.ready is
// high, so a request occupies the output for three results. Each result
// passes the QUEUE_DEPTH-entry queue between the classifier and the
// output sequencer, which absorbs bursts; input stalls only if it is full.
module pak_access_framer_checker_unit #(
  parameter int BLOCK_BYTES = pafc_pkg::BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = pafc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pafc_in_if.sink     in_ch,
  pafc_out_if.source  out_ch
);

  pafc_pkg::job_t push_job, head_job;
  logic           push_valid, push_ready, head_valid, pop;

  pafc_front #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  pafc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop)
  );

  pafc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== verif/pafc_checker.sv =====
`timescale 1ns / 1ps

module pafc_checker #(
  parameter int BLOCK_BYTES = pafc_pkg::BLOCK_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  pafc_in_if   in_ch,
  pafc_out_if  out_ch,
  output int   fail_count,
  output int   pending
);
  import pafc_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    logic [1:0] status;
    logic       last;
  } pak_result_t;

  // checksum entries, address bit k picks the 5-bit slice at 5*k
  localparam logic [54:0] ADDR_SUM_TAB = {5'h01, 5'h1A, 5'h0D, 5'h1C, 5'h0E, 5'h07,
                                          5'h19, 5'h16, 5'h0B, 5'h1F, 5'h15};

  pak_result_t awaited_results[$];
  pak_result_t got, want;
  logic [1:0]  access_mode;
  logic [5:0]  frame_count;
  logic [7:0]  frame_crc;
  int          mismatches = 0;
  int          outstanding = 0;

  assign fail_count = mismatches;
  assign pending = outstanding;

  function automatic logic [7:0] crc_after(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [4:0] addr_checksum(input logic [10:0] addr);
    logic [4:0] sum;
    sum = 5'h00;
    for (int k = 0; k < 11; k++) begin
      if (addr[k]) begin
        sum = sum ^ ADDR_SUM_TAB[5*k +: 5];
      end
    end
    return sum;
  endfunction

  function automatic pak_result_t tx_result(input logic [7:0] b, input logic fin);
    return {KIND_TX, b, ST_OK, fin};
  endfunction

  task automatic restart_frame(input logic [1:0] next_mode);
    access_mode = next_mode;
    frame_count = '0;
    frame_crc = 8'h00;
  endtask

  // work out the results one accepted item causes and advance the access state
  task automatic frame_expected(input logic [1:0] cmd, input logic [10:0] addr,
                                input logic [7:0] b, input logic fend);
    logic [15:0] word;
    logic [1:0]  st;
    word = {addr, addr_checksum(addr)};
    case (cmd)
      CMD_READ_REQ, CMD_WRITE_REQ: begin
        awaited_results.push_back(tx_result(cmd == CMD_READ_REQ ? CMD_READ_BYTE
                                                                 : CMD_WRITE_BYTE, 1'b0));
        awaited_results.push_back(tx_result(word[15:8], 1'b0));
        awaited_results.push_back(tx_result(word[7:0], 1'b1));
        restart_frame(cmd == CMD_READ_REQ ? MODE_READING : MODE_WRITING);
      end
      CMD_PAYLOAD: begin
        if (access_mode == MODE_WRITING) begin
          frame_crc = crc_after(frame_crc, b);
          if (frame_count != CNT_MAX) frame_count++;
          if (frame_count >= BLOCK_BYTES) begin
            awaited_results.push_back(tx_result(b, 1'b0));
            awaited_results.push_back(tx_result(frame_crc, 1'b1));
            restart_frame(MODE_IDLE);
          end else begin
            awaited_results.push_back(tx_result(b, 1'b1));
          end
        end
      end
      default: begin
        if (access_mode == MODE_READING) begin
          // the byte right after the block is the check byte: fold it in by xor
          if (frame_count < BLOCK_BYTES) frame_crc = crc_after(frame_crc, b);
          else if (frame_count == BLOCK_BYTES) frame_crc = frame_crc ^ b;
          if (fend) begin
            if (frame_count != BLOCK_BYTES) st = ST_LENGTH;
            else if (frame_crc != 8'h00) st = ST_CRC;
            else st = ST_OK;
            awaited_results.push_back({KIND_STATUS, 8'h00, st, 1'b1});
            restart_frame(MODE_IDLE);
          end else if (frame_count != CNT_MAX) begin
            frame_count++;
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      restart_frame(MODE_IDLE);
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.result_kind, out_ch.tx_byte, out_ch.status, out_ch.last};
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: kind %0d tx %0h status %0d last %0d",
                 got.kind, got.tx, got.status, got.last);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(got.kind));
          check_field("tx_byte", want.tx, got.tx);
          check_field("status", 8'(want.status), 8'(got.status));
          check_field("last", 8'(want.last), 8'(got.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        frame_expected(in_ch.command, in_ch.block_address, in_ch.data_byte, in_ch.frame_end);
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import pafc_pkg::*;

  localparam int BLK = BLOCK_BYTES_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 220;

  typedef enum int {
    SEQ_READ_GOOD,
    SEQ_READ_BAD_CRC,
    SEQ_READ_BAD_LEN,
    SEQ_READ_OVERRUN,
    SEQ_WRITE_FULL,
    SEQ_WRITE_CUT,
    SEQ_NOISE
  } access_seq_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  int   framed_items = 0;
  int   stray_items = 0;
  int   read_frames = 0;
  int   write_frames = 0;
  int   rx_stall = 0;
  int   rx_draw;
  bit   tx_rush = 1'b0;
  bit   rx_rush = 1'b0;

  pafc_in_if  in_ch();
  pafc_out_if out_ch();

  pak_access_framer_checker_unit #(.BLOCK_BYTES(BLK)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pafc_checker #(.BLOCK_BYTES(BLK)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: hold ready low for a drawn number of cycles after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if ($urandom_range(0, 15) == 0) rx_rush = !rx_rush;
      rx_draw = rx_rush ? 0 : $urandom_range(0, 16);
      rx_stall <= rx_draw;
      out_ch.ready <= (rx_draw == 0);
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ch.ready <= (rx_stall == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pak_access_framer_checker_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    return c;
  endfunction

  // call right after a rising edge; returns at the edge of the transfer
  task automatic send_item(input logic [1:0] cmd, input logic [10:0] addr,
                           input logic [7:0] b, input logic fend);
    int gap;
    gap = tx_rush ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.block_address <= addr;
    in_ch.data_byte <= b;
    in_ch.frame_end <= fend;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic framed(input logic [1:0] cmd, input logic [10:0] addr,
                        input logic [7:0] b, input logic fend);
    send_item(cmd, addr, b, fend);
    framed_items++;
  endtask

  // n_bytes counts every response byte; the last one carries frame_end
  task automatic read_frame(input int n_bytes, input bit bad_crc);
    logic [7:0] crc;
    logic [7:0] b;
    framed(CMD_READ_REQ, 11'($urandom), 8'($urandom), 1'($urandom));
    crc = 8'h00;
    for (int i = 0; i < n_bytes; i++) begin
      b = 8'($urandom);
      if (i < BLK) crc = crc8_next(crc, b);
      else if (i == BLK) b = crc ^ (bad_crc ? 8'($urandom_range(1, 255)) : 8'h00);
      framed(CMD_RESPONSE, 11'($urandom), b, i == n_bytes - 1);
    end
    read_frames++;
  endtask

  task automatic write_frame(input int n_payload);
    framed(CMD_WRITE_REQ, 11'($urandom), 8'($urandom), 1'($urandom));
    for (int i = 0; i < n_payload; i++) begin
      framed(CMD_PAYLOAD, 11'($urandom), 8'($urandom), 1'($urandom));
    end
    write_frames++;
  endtask

  task automatic run_seq(input access_seq_e kind);
    int n;
    tx_rush = ($urandom_range(0, 3) == 0);
    case (kind)
      SEQ_READ_GOOD:    read_frame(BLK + 1, 1'b0);
      SEQ_READ_BAD_CRC: read_frame(BLK + 1, 1'b1);
      SEQ_READ_BAD_LEN: begin
        n = $urandom_range(1, BLK + 8);
        if (n == BLK + 1) n++;
        read_frame(n, 1'($urandom_range(0, 1)));
      end
      SEQ_READ_OVERRUN: read_frame($urandom_range(66, 72), 1'b0);
      SEQ_WRITE_FULL:   write_frame(BLK);
      SEQ_WRITE_CUT:    write_frame($urandom_range(0, BLK - 1));
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          send_item(2'($urandom), 11'($urandom), 8'($urandom), 1'($urandom));
          stray_items++;
        end
      end
    endcase
  endtask

  initial begin
    int pick;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_READ_REQ;
    in_ch.block_address <= '0;
    in_ch.data_byte <= '0;
    in_ch.frame_end <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray bytes while idle, address extremes, aborted and short accesses
    send_item(CMD_PAYLOAD, 11'h000, 8'hFF, 1'b0);
    send_item(CMD_RESPONSE, 11'h7FF, 8'h00, 1'b1);
    framed(CMD_READ_REQ, 11'h000, 8'h00, 1'b0);
    framed(CMD_READ_REQ, 11'h7FF, 8'hFF, 1'b1);
    framed(CMD_RESPONSE, 11'h000, 8'h00, 1'b1);
    framed(CMD_WRITE_REQ, 11'h400, 8'h00, 1'b0);
    framed(CMD_PAYLOAD, 11'h000, 8'h00, 1'b0);
    framed(CMD_PAYLOAD, 11'h7FF, 8'hFF, 1'b1);
    framed(CMD_READ_REQ, 11'h001, 8'h00, 1'b0);
    framed(CMD_RESPONSE, 11'h000, 8'hA5, 1'b0);
    framed(CMD_RESPONSE, 11'h000, 8'h5A, 1'b1);
    framed(CMD_WRITE_REQ, 11'h555, 8'h00, 1'b0);
    send_item(CMD_RESPONSE, 11'h000, 8'h33, 1'b1);
    framed(CMD_PAYLOAD, 11'h2AA, 8'h80, 1'b0);
    framed(CMD_READ_REQ, 11'h2AA, 8'h00, 1'b0);
    send_item(CMD_PAYLOAD, 11'h000, 8'h01, 1'b0);
    framed(CMD_RESPONSE, 11'h000, 8'h7F, 1'b1);

    // random: first one of each key frame shape, then a weighted mix
    framed_items = 0;
    run_seq(SEQ_READ_OVERRUN);
    run_seq(SEQ_READ_GOOD);
    run_seq(SEQ_READ_BAD_CRC);
    run_seq(SEQ_WRITE_FULL);
    while (framed_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: run_seq(SEQ_READ_GOOD);
        3:       run_seq(SEQ_READ_BAD_CRC);
        4:       run_seq(SEQ_READ_BAD_LEN);
        5, 6:    run_seq(SEQ_WRITE_FULL);
        7:       run_seq(SEQ_WRITE_CUT);
        8:       run_seq(SEQ_NOISE);
        default: run_seq($urandom_range(0, 3) == 0 ? SEQ_READ_OVERRUN : SEQ_READ_BAD_LEN);
      endcase
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("ran %0d framed items after the directed set: %0d read and %0d write accesses",
             framed_items, read_frames, write_frames);
    $display("plus %0d stray items; reads hit ok, CRC mismatch, short, long and saturated",
             stray_items);
    if (fail_count == 0) begin
      $display("pak_access_framer_checker_unit regression: pass");
    end else begin
      $display("pak_access_framer_checker_unit regression: fail");
    end
    $finish;
  end

endmodule
